// ===== rtl/mli_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the map linear interpolator. No dependencies.
package mli_pkg;

	// table geometry
	localparam int MAP_DEPTH = 1024;
	localparam int IDX_W     = $clog2(MAP_DEPTH);
	localparam int CNT_W     = $clog2(MAP_DEPTH + 1);

	// field widths
	localparam int DATA_W    = 32;
	localparam int KIND_W    = 2;
	localparam int STAT_W    = 3;
	localparam int CFG_IDX_W = 1;

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_USE_MAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BP_RATE = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_STORED   = 3'd1,
		STAT_REJECT   = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_UNSORTED = 3'd4,
		STAT_FEW      = 3'd5,
		STAT_SAT      = 3'd6
	} status_t;

	// multiplier operand select
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_RATE,
		MUL_INTERP
	} mul_sel_t;

	// result register source
	typedef enum logic [3:0] {
		RES_NONE,
		RES_CODE,
		RES_APPEND,
		RES_FIRST,
		RES_LAST,
		RES_HI,
		RES_LO,
		RES_RATE,
		RES_INTERP
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SRCH,
		ST_SRCH_WAIT,
		ST_CAP_HI,
		ST_CAP_LO,
		ST_CHECK,
		ST_MUL_RATE,
		ST_RATE_RES,
		ST_MUL_INTERP,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_RES,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic     load;
		logic     clear;
		logic     append;
		logic     srch_init;
		logic     srch_read;
		logic     srch_upd;
		logic     rd_hi;
		logic     cap_hi;
		logic     cap_lo;
		logic     prep;
		logic     div_init;
		logic     div_step;
		logic     push;
		mul_sel_t mul_sel;
		res_sel_t res_sel;
		status_t  res_code;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_t kind;
		logic  use_map;
		logic  unsorted;
		logic  few;
		logic  below_first;
		logic  above_last;
		logic  srch_done;
		logic  hit;
		logic  span_zero;
		logic  div_last;
		logic  out_free;
	} dp_sts_t;

endpackage

// ===== rtl/mli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mli_ctrl.sv =====
// Controller state machine: sequences one request at a time through the datapath.
// Depends on mli_pkg.
module mli_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mli_pkg::dp_sts_t sts,
	output mli_pkg::dp_cmd_t cmd
);
	import mli_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.kind == KIND_QUERY && !sts.use_map) begin
					state_d = ST_MUL_RATE;
				end else if (sts.kind == KIND_QUERY && !sts.unsorted && !sts.few &&
				             !sts.below_first && !sts.above_last) begin
					state_d = ST_SRCH;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SRCH: begin
				state_d = sts.srch_done ? ST_CAP_HI : ST_SRCH_WAIT;
			end
			ST_SRCH_WAIT:  state_d = ST_SRCH;
			ST_CAP_HI:     state_d = ST_CAP_LO;
			ST_CAP_LO:     state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = (sts.hit || sts.span_zero) ? ST_FINISH : ST_MUL_INTERP;
			end
			ST_MUL_RATE:   state_d = ST_RATE_RES;
			ST_RATE_RES:   state_d = ST_FINISH;
			ST_MUL_INTERP: state_d = ST_DIV_INIT;
			ST_DIV_INIT:   state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) state_d = ST_DIV_RES;
			end
			ST_DIV_RES:    state_d = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_NONE;
		cmd.res_sel  = RES_NONE;
		cmd.res_code = STAT_OK;
		in_stall     = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_DECODE: begin
				unique case (sts.kind)
					KIND_CLEAR: begin
						cmd.clear    = 1'b1;
						cmd.res_sel  = RES_CODE;
						cmd.res_code = STAT_STORED;
					end
					KIND_APPEND: begin
						cmd.append  = 1'b1;
						cmd.res_sel = RES_APPEND;
					end
					KIND_QUERY: begin
						priority if (!sts.use_map) begin
							cmd.mul_sel = MUL_RATE;
						end else if (sts.unsorted) begin
							cmd.res_sel  = RES_CODE;
							cmd.res_code = STAT_UNSORTED;
						end else if (sts.few) begin
							cmd.res_sel  = RES_CODE;
							cmd.res_code = STAT_FEW;
						end else if (sts.below_first) begin
							cmd.res_sel = RES_FIRST;
						end else if (sts.above_last) begin
							cmd.res_sel = RES_LAST;
						end else begin
							cmd.srch_init = 1'b1;
						end
					end
					default: begin
						cmd.res_sel  = RES_CODE;
						cmd.res_code = STAT_REJECT;
					end
				endcase
			end
			ST_SRCH: begin
				cmd.rd_hi     = sts.srch_done;
				cmd.srch_read = !sts.srch_done;
			end
			ST_SRCH_WAIT: cmd.srch_upd = 1'b1;
			ST_CAP_HI:    cmd.cap_hi   = 1'b1;
			ST_CAP_LO:    cmd.cap_lo   = 1'b1;
			ST_CHECK: begin
				cmd.prep = 1'b1;
				priority if (sts.hit) begin
					cmd.res_sel = RES_HI;
				end else if (sts.span_zero) begin
					cmd.res_sel = RES_LO;
				end else begin
					cmd.res_sel = RES_NONE;
				end
			end
			ST_MUL_RATE:   cmd.mul_sel  = MUL_RATE;
			ST_RATE_RES:   cmd.res_sel  = RES_RATE;
			ST_MUL_INTERP: cmd.mul_sel  = MUL_INTERP;
			ST_DIV_INIT:   cmd.div_init = 1'b1;
			ST_DIV:        cmd.div_step = 1'b1;
			ST_DIV_RES:    cmd.res_sel  = RES_INTERP;
			ST_FINISH:     cmd.push     = sts.out_free;
			default: begin
				cmd.res_sel = RES_NONE;
			end
		endcase
	end

endmodule

// ===== rtl/mli_dp.sv =====
// Datapath: point table RAM, configuration, binary search, multiplier,
// restoring divider and output register. Depends on mli_pkg and mli_ram.
module mli_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mli_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mli_pkg::DATA_W-1:0]            cfg_data,
	input  logic [mli_pkg::KIND_W-1:0]            kind,
	input  logic [mli_pkg::DATA_W-1:0]            position,
	input  logic [mli_pkg::DATA_W-1:0]            map_distance,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mli_pkg::DATA_W-1:0]            distance,
	output logic [mli_pkg::STAT_W-1:0]            status,
	input  mli_pkg::dp_cmd_t                      cmd,
	output mli_pkg::dp_sts_t                      sts
);
	import mli_pkg::*;

	// configuration
	logic              use_map_q;
	logic [DATA_W-1:0] bp_rate_q;

	// captured request
	kind_t             kind_q;
	logic [DATA_W-1:0] pos_q;
	logic [DATA_W-1:0] dist_q;

	// table bookkeeping
	logic [CNT_W-1:0]  count_q;
	logic              unsorted_q;
	logic [DATA_W-1:0] first_pos_q, first_dist_q;
	logic [DATA_W-1:0] last_pos_q, last_dist_q;

	// search
	logic [IDX_W-1:0]  lo_q, hi_q, mid_q, mid_c;
	logic [DATA_W-1:0] hi_pos_q, hi_dist_q, lo_pos_q, lo_dist_q;

	// arithmetic
	logic              neg_q;
	logic [DATA_W-1:0] mag_a_q, mag_b_q, span_q;
	logic [DATA_W-1:0] mul_a, mul_b;
	logic [2*DATA_W-1:0] prod_c, prod_q;
	logic [DATA_W-1:0] rem_q, sh_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DATA_W:0]   div_trial, div_sub;
	logic              div_ge;

	// result
	logic [DATA_W-1:0] res_dist_q, res_dist_d;
	status_t           res_stat_q, res_stat_d;
	status_t           app_stat;
	logic              app_ok, app_down;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] distance_q;
	status_t           status_q;

	// RAM
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [2*DATA_W-1:0] ram_wdata, ram_rdata;
	logic [DATA_W-1:0] rd_pos, rd_dist;

	mli_ram #(
		.WIDTH(2*DATA_W),
		.DEPTH(MAP_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_pos  = ram_rdata[2*DATA_W-1:DATA_W];
	assign rd_dist = ram_rdata[DATA_W-1:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_map_q <= 1'b0;
			bp_rate_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_USE_MAP: use_map_q <= cfg_data[0];
				CFG_BP_RATE: bp_rate_q <= cfg_data;
				default:     use_map_q <= use_map_q;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			pos_q  <= position;
			dist_q <= map_distance;
		end
	end

	// append decision
	assign app_down = (count_q != '0) && (pos_q < last_pos_q);
	assign app_ok   = (pos_q != '0) && (count_q < CNT_W'(MAP_DEPTH));
	always_comb begin
		priority if (pos_q == '0) begin
			app_stat = STAT_REJECT;
		end else if (!app_ok) begin
			app_stat = STAT_FULL;
		end else if (app_down) begin
			app_stat = STAT_UNSORTED;
		end else begin
			app_stat = STAT_STORED;
		end
	end

	assign ram_we    = cmd.append && app_ok;
	assign ram_waddr = count_q[IDX_W-1:0];
	assign ram_wdata = {pos_q, dist_q};

	// table count and unsorted flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			unsorted_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q    <= '0;
			unsorted_q <= 1'b0;
		end else if (ram_we) begin
			count_q    <= count_q + CNT_W'(1);
			unsorted_q <= unsorted_q | app_down;
		end
	end

	// end points kept in flops for clamping
	always_ff @(posedge clk) begin
		if (ram_we) begin
			last_pos_q  <= pos_q;
			last_dist_q <= dist_q;
			if (count_q == '0) begin
				first_pos_q  <= pos_q;
				first_dist_q <= dist_q;
			end
		end
	end

	// binary search for the first point at or above the query
	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		ram_re    = cmd.srch_read | cmd.rd_hi | cmd.cap_hi;
		priority if (cmd.srch_read) begin
			ram_raddr = mid_c;
		end else if (cmd.cap_hi) begin
			ram_raddr = hi_q - IDX_W'(1);
		end else begin
			ram_raddr = hi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			lo_q <= IDX_W'(1);
			hi_q <= IDX_W'(count_q - CNT_W'(1));
		end else if (cmd.srch_upd) begin
			if (rd_pos < pos_q) begin
				lo_q <= mid_q + IDX_W'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.srch_read) begin
			mid_q <= mid_c;
		end
		if (cmd.cap_hi) begin
			hi_pos_q  <= rd_pos;
			hi_dist_q <= rd_dist;
		end
		if (cmd.cap_lo) begin
			lo_pos_q  <= rd_pos;
			lo_dist_q <= rd_dist;
		end
	end

	// operands for interpolation
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			neg_q   <= hi_dist_q < lo_dist_q;
			mag_a_q <= (hi_dist_q < lo_dist_q) ? lo_dist_q - hi_dist_q
			                                   : hi_dist_q - lo_dist_q;
			mag_b_q <= pos_q - lo_pos_q;
			span_q  <= hi_pos_q - lo_pos_q;
		end
	end

	// shared multiplier, product registered
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_INTERP: begin
				mul_a = mag_a_q;
				mul_b = mag_b_q;
			end
			default: begin
				mul_a = pos_q;
				mul_b = bp_rate_q;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= prod_c;
		end
	end

	// restoring divider: quotient bits shift in as dividend bits shift out
	assign div_trial = {rem_q, sh_q[DATA_W-1]};
	assign div_ge    = div_trial >= {1'b0, span_q};
	assign div_sub   = div_trial - {1'b0, span_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q     <= prod_q[2*DATA_W-1:DATA_W];
			sh_q      <= prod_q[DATA_W-1:0];
			div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			rem_q     <= div_ge ? div_sub[DATA_W-1:0] : div_trial[DATA_W-1:0];
			sh_q      <= {sh_q[DATA_W-2:0], div_ge};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	// result select
	always_comb begin
		res_dist_d = '0;
		res_stat_d = STAT_OK;
		unique case (cmd.res_sel)
			RES_CODE:   res_stat_d = cmd.res_code;
			RES_APPEND: res_stat_d = app_stat;
			RES_FIRST:  res_dist_d = first_dist_q;
			RES_LAST:   res_dist_d = last_dist_q;
			RES_HI:     res_dist_d = hi_dist_q;
			RES_LO:     res_dist_d = lo_dist_q;
			RES_RATE:   res_dist_d = prod_q[2*DATA_W-1:DATA_W];
			RES_INTERP: begin
				// negative slope rounds the magnitude up, so the sum floors
				res_dist_d = neg_q ? lo_dist_q - sh_q - DATA_W'(rem_q != '0)
				                   : lo_dist_q + sh_q;
			end
			default:    res_dist_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_sel != RES_NONE) begin
			res_dist_q <= res_dist_d;
			res_stat_q <= res_stat_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			distance_q <= res_dist_q;
			status_q   <= res_stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign status    = status_q;

	// status to controller
	assign sts.kind        = kind_q;
	assign sts.use_map     = use_map_q;
	assign sts.unsorted    = unsorted_q;
	assign sts.few         = count_q < CNT_W'(2);
	assign sts.below_first = pos_q <= first_pos_q;
	assign sts.above_last  = pos_q >= last_pos_q;
	assign sts.srch_done   = lo_q >= hi_q;
	assign sts.hit         = hi_pos_q == pos_q;
	assign sts.span_zero   = hi_pos_q == lo_pos_q;
	assign sts.div_last    = div_cnt_q == '0;
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

// ===== rtl/map_linear_interpolator.sv =====
// Map linear interpolator: genetic distance lookup over a table of up to
// MAP_DEPTH base positions, with clamping, exact match and floor interpolation.
// Depends on mli_pkg, mli_ctrl, mli_dp (and through it mli_ram).
//
// One request is worked at a time. Clear, append, clamped or rejected queries
// pass from decode straight to the result and output registers. A rate-mode
// query does one 32x32 multiply. An interpolating query runs a binary search
// over the point RAM, about log2 of the point count steps of a RAM read and
// then an update, reads the two flanking points, then one multiply and a
// 32-step restoring divider. The registered RAM read sets the search time and
// the one-bit-per-cycle divider the rest. The result sits in an output
// register, and the next request is taken once the current one has been moved
// there.
// The point RAM needs no clearing: only entries below the point count are read.
module map_linear_interpolator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mli_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mli_pkg::DATA_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mli_pkg::KIND_W-1:0]        kind,
	input  logic [mli_pkg::DATA_W-1:0]        position,
	input  logic [mli_pkg::DATA_W-1:0]        map_distance,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mli_pkg::DATA_W-1:0]        distance,
	output logic [mli_pkg::STAT_W-1:0]        status
);
	import mli_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mli_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	mli_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.position    (position),
		.map_distance(map_distance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.distance    (distance),
		.status      (status),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
